FILE: src/kwm_pkg.sv
// shared constants, types and helpers for the k-way sorted merge
package kwm_pkg;

  localparam int LANES      = 4;
  localparam int LANE_DEPTH = 16;
  localparam int LANE_REACH = 4;
  localparam int USE_MAX    = (LANES < LANE_REACH) ? LANES : LANE_REACH;

  localparam int VAL_W  = 32;
  localparam int LANE_W = 2;
  localparam int CFG_W  = 3;
  localparam int LIDX_W = $clog2(LANES);
  localparam int PTR_W  = $clog2(LANE_DEPTH);
  localparam int CNT_W  = $clog2(LANE_DEPTH + 1);

  localparam int IN_DATA_W  = ((VAL_W + LANE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VAL_W + LANE_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - VAL_W - LANE_W;

  localparam logic [CFG_W-1:0] LANES_RESET = 3'd4;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OVF,
    ST_FETCH,
    ST_PICK
  } kwm_state_e;

  typedef struct packed {
    logic take_item;
    logic take_cfg;
    logic emit_ovf;
    logic pop;
    logic clear;
  } kwm_cmd_t;

  typedef struct packed {
    logic ovf_hit;
    logic can_pop;
    logic last_after;
    logic done_now;
    logic out_free;
  } kwm_status_t;

  // clamp the lane count register into the range the block really has
  function automatic logic [CFG_W-1:0] eff_lanes(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] u;
    u = v;
    if (u == '0) u = CFG_W'(1);
    if (u > CFG_W'(USE_MAX)) u = CFG_W'(USE_MAX);
    return u;
  endfunction

endpackage

FILE: src/k_way_sorted_merge_top.sv
// top level of the k-way sorted merge
// Merges up to LANES ascending signed 32-bit streams into one ascending stream.
// Each request on the input channel either pushes a value into a lane buffer
// (tuser = 0) or closes the lane (tuser = 1). After every request the block
// emits the smallest buffered head for as long as every open lane holds an
// element; equal heads go to the highest-numbered lane. A push into a full lane
// is dropped and answered with one result flagged in tuser. When all lanes in
// use are closed and drained, the final result carries tlast and the block
// clears itself; closing the last lane with nothing buffered clears it silently.
// Writing lanes_in_use (0 acts as 1, values above the lane count are clipped)
// also clears the merge in progress. An accepted request goes through the fetch
// and pick states for the head compare, and each pop that ends no merge leads to
// a new fetch, since each lane buffer is a ram with a registered read that must
// be refetched after a pop before the next compare. A dropped push is answered
// from an overflow state first. No clearing pass is needed after reset:
// per-lane fill counts mark what is valid. The result register decouples the
// output: a new request is taken while the last result still waits.
module k_way_sorted_merge_top
  import kwm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input requests
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,   // lane [1:0], value [33:2], zero pad
  input  logic                  s_tuser_i,   // operation: 0 push, 1 close
  // merged results
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o,   // value_out [31:0], from_lane [33:32], pad
  output logic                  m_tuser_o,   // overflow
  output logic                  m_tlast_o,   // last element of the merge
  // lanes_in_use register write
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  kwm_cmd_t    cmd;
  kwm_status_t status;

  // sequencer: accept, overflow result, fetch heads, pick and pop
  kwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_tvalid_i),
    .cfg_valid_i (cfg_valid_i),
    .status_i    (status),
    .in_tready_o (s_tready_o),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  // lane buffers, counts, pointers, head compare and result register
  kwm_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_tdata_i   (s_tdata_i),
    .in_tuser_i   (s_tuser_i),
    .cfg_data_i   (cfg_data_i),
    .out_tvalid_o (m_tvalid_o),
    .out_tready_i (m_tready_i),
    .out_tdata_o  (m_tdata_o),
    .out_tuser_o  (m_tuser_o),
    .out_tlast_o  (m_tlast_o)
  );

endmodule

FILE: src/kwm_ram.sv
// generic single write port ram with registered read
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/kwm_ctrl.sv
// sequencer for the k-way sorted merge
module kwm_ctrl
  import kwm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_tvalid_i,
  input  logic        cfg_valid_i,
  input  kwm_status_t status_i,
  output logic        in_tready_o,
  output logic        cfg_ready_o,
  output kwm_cmd_t    cmd_o
);

  kwm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_tvalid_i && !cfg_valid_i) begin
          state_d = status_i.ovf_hit ? ST_OVF : ST_FETCH;
        end
      end
      ST_OVF: begin
        if (status_i.out_free) state_d = ST_FETCH;
      end
      ST_FETCH: state_d = ST_PICK;
      ST_PICK: begin
        if (status_i.can_pop) begin
          if (status_i.out_free) begin
            state_d = status_i.last_after ? ST_IDLE : ST_FETCH;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready_o = 1'b0;
    cfg_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        cfg_ready_o     = 1'b1;
        in_tready_o     = !cfg_valid_i;
        cmd_o.take_cfg  = cfg_valid_i;
        cmd_o.take_item = in_tvalid_i && !cfg_valid_i;
      end
      ST_OVF: begin
        cmd_o.emit_ovf = status_i.out_free;
      end
      ST_FETCH: begin
        cmd_o = '0;
      end
      ST_PICK: begin
        cmd_o.pop   = status_i.can_pop && status_i.out_free;
        cmd_o.clear = (status_i.can_pop && status_i.out_free && status_i.last_after)
                      || (!status_i.can_pop && status_i.done_now);
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: src/kwm_datapath.sv
// lane buffers, lane bookkeeping, head compare and output register
module kwm_datapath
  import kwm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kwm_cmd_t              cmd_i,
  output kwm_status_t           status_o,
  input  logic [IN_DATA_W-1:0]  in_tdata_i,
  input  logic                  in_tuser_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  output logic                  out_tvalid_o,
  input  logic                  out_tready_i,
  output logic [OUT_DATA_W-1:0] out_tdata_o,
  output logic                  out_tuser_o,
  output logic                  out_tlast_o
);

  localparam logic [VAL_W-1:0] SIGN_FLIP = {1'b1, {(VAL_W-1){1'b0}}};

  logic [CNT_W-1:0]  cnt_q [LANES];
  logic [CNT_W-1:0]  cnt_d [LANES];
  logic [PTR_W-1:0]  rp_q  [LANES];
  logic [PTR_W-1:0]  rp_d  [LANES];
  logic [LANES-1:0]  closed_q, closed_d;
  logic [CFG_W-1:0]  use_q, use_d;
  logic [VAL_W-1:0]  head  [LANES];

  logic [LANE_W-1:0] item_lane_q;
  logic [VAL_W-1:0]  item_value_q;

  logic              out_valid_q;
  logic [VAL_W-1:0]  out_value_q;
  logic [LANE_W-1:0] out_lane_q;
  logic              out_last_q;
  logic              out_ovf_q;

  logic [LANE_W-1:0] in_lane;
  logic [VAL_W-1:0]  in_value;
  logic [LIDX_W-1:0] in_idx;
  logic              lane_ok;
  logic              in_full;
  logic              push_ok;
  logic              push_en;
  logic              close_en;
  logic [CNT_W:0]    wsum;
  logic [PTR_W-1:0]  wptr;

  logic              ready, found, all_empty, rest_busy;
  logic [LIDX_W-1:0] best;
  logic [VAL_W-1:0]  best_key;
  logic [VAL_W-1:0]  key;
  logic              out_free;
  logic              out_load;

  // input fields
  assign in_lane  = in_tdata_i[LANE_W-1:0];
  assign in_value = in_tdata_i[LANE_W +: VAL_W];
  assign in_idx   = LIDX_W'(in_lane);
  assign lane_ok  = int'(in_lane) < LANES;
  assign in_full  = cnt_q[in_idx] == CNT_W'(LANE_DEPTH);
  assign push_ok  = lane_ok && (in_tuser_i == OP_PUSH) && !closed_q[in_idx];
  assign push_en  = cmd_i.take_item && push_ok && !in_full;
  assign close_en = cmd_i.take_item && lane_ok && (in_tuser_i == OP_CLOSE);

  // circular write position behind the lane's head
  always_comb begin
    wsum = (CNT_W+1)'(rp_q[in_idx]) + (CNT_W+1)'(cnt_q[in_idx]);
    if (wsum >= (CNT_W+1)'(LANE_DEPTH)) wsum = wsum - (CNT_W+1)'(LANE_DEPTH);
    wptr = PTR_W'(wsum);
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    kwm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (LANE_DEPTH)
    ) u_buf (
      .clk_i   (clk_i),
      .we_i    (push_en && (in_idx == LIDX_W'(g))),
      .waddr_i (wptr),
      .wdata_i (in_value),
      .raddr_i (rp_q[g]),
      .rdata_o (head[g])
    );
  end

  // smallest head, ties to the higher lane
  always_comb begin
    ready     = 1'b1;
    found     = 1'b0;
    all_empty = 1'b1;
    best      = '0;
    best_key  = '0;
    key       = '0;
    for (int l = 0; l < LANES; l++) begin
      if (cnt_q[l] != '0) begin
        all_empty = 1'b0;
        key = head[l] ^ SIGN_FLIP;
        if (!found || key <= best_key) begin
          best     = LIDX_W'(l);
          best_key = key;
          found    = 1'b1;
        end
      end else if (!closed_q[l]) begin
        ready = 1'b0;
      end
    end
  end

  // anything left once the chosen head is taken
  always_comb begin
    rest_busy = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if (LIDX_W'(l) == best) begin
        if (cnt_q[l] != CNT_W'(1)) rest_busy = 1'b1;
      end else if (cnt_q[l] != '0) begin
        rest_busy = 1'b1;
      end
    end
  end

  assign out_free = !out_valid_q || out_tready_i;
  assign out_load = cmd_i.pop || cmd_i.emit_ovf;

  assign status_o.ovf_hit    = push_ok && in_full;
  assign status_o.can_pop    = ready && found;
  assign status_o.last_after = (&closed_q) && !rest_busy;
  assign status_o.done_now   = (&closed_q) && all_empty;
  assign status_o.out_free   = out_free;

  // lane bookkeeping
  always_comb begin
    cnt_d    = cnt_q;
    rp_d     = rp_q;
    closed_d = closed_q;
    use_d    = use_q;
    if (push_en) cnt_d[in_idx] = cnt_q[in_idx] + CNT_W'(1);
    if (close_en) closed_d[in_idx] = 1'b1;
    if (cmd_i.pop) begin
      cnt_d[best] = cnt_q[best] - CNT_W'(1);
      if (rp_q[best] == PTR_W'(LANE_DEPTH - 1)) begin
        rp_d[best] = '0;
      end else begin
        rp_d[best] = rp_q[best] + PTR_W'(1);
      end
    end
    if (cmd_i.take_cfg) use_d = eff_lanes(cfg_data_i);
    if (cmd_i.clear || cmd_i.take_cfg) begin
      for (int l = 0; l < LANES; l++) begin
        cnt_d[l]    = '0;
        rp_d[l]     = '0;
        closed_d[l] = l >= int'(use_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q       <= eff_lanes(LANES_RESET);
      out_valid_q <= 1'b0;
      for (int l = 0; l < LANES; l++) begin
        cnt_q[l]    <= '0;
        rp_q[l]     <= '0;
        closed_q[l] <= l >= int'(eff_lanes(LANES_RESET));
      end
    end else begin
      use_q    <= use_d;
      cnt_q    <= cnt_d;
      rp_q     <= rp_d;
      closed_q <= closed_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      item_lane_q  <= in_lane;
      item_value_q <= in_value;
    end
    if (cmd_i.pop) begin
      out_value_q <= head[best];
      out_lane_q  <= LANE_W'(best);
      out_last_q  <= status_o.last_after;
      out_ovf_q   <= 1'b0;
    end else if (cmd_i.emit_ovf) begin
      out_value_q <= item_value_q;
      out_lane_q  <= item_lane_q;
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b1;
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = {{OUT_PAD_W{1'b0}}, out_lane_q, out_value_q};
  assign out_tuser_o  = out_ovf_q;
  assign out_tlast_o  = out_last_q;

  // a merge that ends or is cleared leaves no element behind
  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> all_empty)
    else $error("lane counts not zero after clear");

  // an overflow result only follows a push into a full lane
  a_ovf_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_ovf |-> cnt_q[LIDX_W'(item_lane_q)] == CNT_W'(LANE_DEPTH))
    else $error("overflow result for a lane that is not full");

  // a pop or an overflow result never loads over a result still waiting
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_tready_i) |-> !out_load)
    else $error("result register overwritten");

endmodule

FILE: sim/k_way_sorted_merge_top_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the k-way sorted merge top level
module k_way_sorted_merge_top_tb
  import kwm_pkg::*;
();

  localparam int RESULTS_PER_REQ = 64;   // cap on results one request can release
  localparam int LONG_HOLD       = 200;  // cycles the receiver backs off once
  localparam int SETTLE_CYCLES   = 16;   // covers accept, fetch, pick and a silent clear
  localparam int REPORT_LIMIT    = 10;
  localparam int PHASE_REQS      = 15;
  localparam int PLAN_LEN        = 8;
  // lane counts walked through after the directed part, out-of-range ones included
  localparam logic [CFG_W-1:0] LANE_PLAN [PLAN_LEN] =
    '{3'd1, 3'd2, 3'd0, 3'd3, 3'd7, 3'd5, 3'd6, 3'd4};

  typedef struct {
    logic [VAL_W-1:0]  value;
    logic [LANE_W-1:0] lane;
    logic              last;
    logic              ovf;
  } merged_item_t;

  // predicts the merged stream and checks what the block puts out
  class merge_scoreboard;
    logic [VAL_W-1:0] lane_fifo [LANES][$];
    bit               lane_shut [LANES];
    int               lanes_active;
    merged_item_t     due_results [$];
    int               mismatches;
    int               results_seen;
    int               requests_seen;
    int               merges_done;
    int               pushes_dropped;

    function new();
      set_lanes(LANES_RESET);
    endfunction

    function void restart();
      for (int l = 0; l < LANES; l++) begin
        lane_fifo[l].delete();
        lane_shut[l] = (l >= lanes_active);
      end
    endfunction

    // a write clips the count to the lanes the block has and drops the merge
    function void set_lanes(input logic [CFG_W-1:0] v);
      if (v == '0) lanes_active = 1;
      else if (int'(v) > USE_MAX) lanes_active = USE_MAX;
      else lanes_active = int'(v);
      restart();
    endfunction

    function bit all_drained();
      for (int l = 0; l < lanes_active; l++)
        if (!lane_shut[l] || lane_fifo[l].size() != 0) return 1'b0;
      return 1'b1;
    endfunction

    function void queue_result(input logic [VAL_W-1:0] v, input int lane,
                               input logic last, input logic ovf);
      merged_item_t item;
      item.value = v;
      item.lane  = LANE_W'(lane);
      item.last  = last;
      item.ovf   = ovf;
      due_results.insert(due_results.size(), item);
    endfunction

    function void note_request(input logic op, input logic [LANE_W-1:0] lane,
                               input logic [VAL_W-1:0] value);
      int               emitted;
      bit               ready;
      bit               found;
      int               best;
      logic [VAL_W-1:0] best_val;
      emitted = 0;
      best = 0;
      best_val = '0;
      requests_seen++;
      // requests to lanes outside the merge are ignored
      if (int'(lane) < lanes_active) begin
        if (op == OP_CLOSE) begin
          lane_shut[lane] = 1'b1;
        end else if (!lane_shut[lane]) begin
          if (lane_fifo[lane].size() >= LANE_DEPTH) begin
            queue_result(value, int'(lane), 1'b0, 1'b1);
            pushes_dropped++;
            emitted++;
          end else begin
            lane_fifo[lane].insert(lane_fifo[lane].size(), value);
          end
        end
      end
      // pop the smallest head while every open lane holds something
      while (emitted < RESULTS_PER_REQ) begin
        ready = 1'b1;
        found = 1'b0;
        for (int l = 0; l < lanes_active; l++) begin
          if (lane_fifo[l].size() != 0) begin
            // ties go to the higher lane
            if (!found || $signed(lane_fifo[l][0]) <= $signed(best_val)) begin
              best = l;
              best_val = lane_fifo[l][0];
              found = 1'b1;
            end
          end else if (!lane_shut[l]) begin
            ready = 1'b0;
          end
        end
        if (!ready || !found) break;
        void'(lane_fifo[best].pop_front());
        if (all_drained()) begin
          queue_result(best_val, best, 1'b1, 1'b0);
          merges_done++;
          restart();
          break;
        end
        queue_result(best_val, best, 1'b0, 1'b0);
        emitted++;
      end
      // every lane closed with nothing left clears silently
      if (all_drained()) restart();
    endfunction

    function void check_result(input logic [VAL_W-1:0] value, input logic [LANE_W-1:0] lane,
                               input logic last, input logic ovf);
      merged_item_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: value %0d lane %0d last %0b overflow %0b",
                   $signed(value), lane, last, ovf);
        return;
      end
      want = due_results.pop_front();
      if (want.value !== value || want.lane !== lane || want.last !== last ||
          want.ovf !== ovf) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result %0d: expected value %0d lane %0d last %0b overflow %0b,",
                   results_seen, $signed(want.value), want.lane, want.last, want.ovf);
          $display("  got value %0d lane %0d last %0b overflow %0b",
                   $signed(value), lane, last, ovf);
        end
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  // every input starts at a known value
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  s_tvalid_i  = 1'b0;
  logic                  s_tready_o;
  logic [IN_DATA_W-1:0]  s_tdata_i   = '0;   // lane [1:0], value [33:2], zero pad
  logic                  s_tuser_i   = 1'b0; // operation
  logic                  m_tvalid_o;
  logic                  m_tready_i  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata_o;          // value_out [31:0], from_lane [33:32], pad
  logic                  m_tuser_o;          // overflow
  logic                  m_tlast_o;          // last element of the merge
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_W-1:0]      cfg_data_i  = '0;

  merge_scoreboard sb;
  bit              hold_armed = 1'b0;  // asks the receiver for one long back-off
  bit              calm       = 1'b0;  // no idling on either side once set
  int              settings_run = 0;

  k_way_sorted_merge_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 0;
  end

  // one request into the block, with an occasional idle burst in front
  task automatic send_request(input logic op, input logic [LANE_W-1:0] lane,
                              input logic [VAL_W-1:0] value);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= IN_DATA_W'({value, lane});
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    sb.note_request(op, lane, value);
  endtask

  // stop offering, let every expected result come out, then give the block
  // time to finish a request that releases nothing
  task automatic settle();
    s_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_lanes(input logic [CFG_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_lanes(v);
    settings_run++;
  endtask

  // one merge: ascending runs per lane pushed in random interleave, some noise,
  // then every lane in use closed in random order, other lanes now and then
  task automatic run_merge(input int pushes);
    logic [VAL_W-1:0] next_val [LANES];
    logic [VAL_W-1:0] base;
    int               order [LANES];
    int               flood;
    int               lane;
    int               j;
    int               tmp;
    bit               shared;
    base = $urandom();
    // a shared start makes lane heads interleave and tie often
    shared = $urandom_range(0, 1);
    for (int l = 0; l < LANES; l++) begin
      next_val[l] = shared ? base : VAL_W'($urandom());
      order[l] = l;
    end
    // a flooded lane tends to fill up and drop pushes
    flood = ($urandom_range(0, 3) == 0) ? $urandom_range(0, sb.lanes_active - 1) : -1;
    for (int k = 0; k < pushes; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_request(1'($urandom_range(0, 1)), LANE_W'($urandom_range(0, LANES - 1)),
                     VAL_W'($urandom()));
      end else begin
        if (flood >= 0 && $urandom_range(0, 3) != 0) lane = flood;
        else if ($urandom_range(0, 9) == 0) lane = $urandom_range(0, LANES - 1);
        else lane = $urandom_range(0, sb.lanes_active - 1);
        send_request(OP_PUSH, LANE_W'(lane), next_val[lane]);
        next_val[lane] = next_val[lane] + VAL_W'($urandom_range(0, 3));
      end
    end
    for (int l = LANES - 1; l > 0; l--) begin
      j = $urandom_range(0, l);
      tmp = order[l];
      order[l] = order[j];
      order[j] = tmp;
    end
    for (int l = 0; l < LANES; l++) begin
      if (order[l] < sb.lanes_active || $urandom_range(0, 3) == 0)
        send_request(OP_CLOSE, LANE_W'(order[l]), VAL_W'($urandom()));
      // late push into a closed or unused lane
      if ($urandom_range(0, 7) == 0)
        send_request(OP_PUSH, LANE_W'(order[l]), VAL_W'($urandom()));
    end
  endtask

  // results are checked at the edge where they are taken
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i)
      sb.check_result(m_tdata_o[VAL_W-1:0], m_tdata_o[VAL_W+LANE_W-1:VAL_W],
                      m_tlast_o, m_tuser_o);
  end

  // receiver: short random stalls, one long back-off on request
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (hold_armed) begin
        hold_armed = 1'b0;
        stall = LONG_HOLD;
      end else if (stall == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 4);
      end
      if (stall > 0) begin
        m_tready_i <= 1'b0;
        stall--;
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int phase_start;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of the value range, a tie going to the higher lane, closes that
    // release waiting heads, a push into a closed lane, an empty close at the end
    send_request(OP_PUSH, 2'd0, 32'h8000_0000);
    send_request(OP_PUSH, 2'd1, 32'h7fff_ffff);
    send_request(OP_PUSH, 2'd2, 32'hffff_ffff);
    send_request(OP_PUSH, 2'd3, 32'h0000_0000);
    send_request(OP_PUSH, 2'd0, 32'hffff_ffff);
    send_request(OP_CLOSE, 2'd2, 32'h0000_0000);
    send_request(OP_PUSH, 2'd2, 32'd5);
    send_request(OP_CLOSE, 2'd0, 32'h0000_0000);
    send_request(OP_CLOSE, 2'd3, 32'h0000_0000);
    send_request(OP_CLOSE, 2'd1, 32'h0000_0000);
    // fill lane 3 and push once more to get a drop; the merge is left open
    // so the next register write has to clear it
    for (int i = 0; i <= LANE_DEPTH; i++)
      send_request(OP_PUSH, 2'd3, (i == LANE_DEPTH) ? VAL_W'($urandom()) : VAL_W'(i * 5 - 40));
    settle();

    for (int p = 0; p < PLAN_LEN; p++) begin
      write_lanes(LANE_PLAN[p]);
      // single lane: every push releases a result, so a long back-off stalls the block and holds off further requests
      if (p == 0) hold_armed = 1'b1;
      if (p == PLAN_LEN - 1) calm = 1'b1;
      phase_start = sb.requests_seen;
      while (sb.requests_seen - phase_start < PHASE_REQS) run_merge($urandom_range(4, 18));
      settle();
    end

    $display("ran %0d requests over %0d lane settings, %0d results checked",
             sb.requests_seen, settings_run, sb.results_seen);
    $display("%0d merges reached their final element, %0d pushes dropped on a full lane",
             sb.merges_done, sb.pushes_dropped);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
